[hw/rtl/prts_pkg.sv]
// Types and constants shared by the ping retry timeout sequencer.
`default_nettype none

package prts_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPLY_TIMEOUT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEXT_DELAY     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPLIES_NEEDED = 2'd2;

   localparam logic [15:0] REPLY_TIMEOUT_RESET  = 16'd300;
   localparam logic [15:0] NEXT_DELAY_RESET     = 16'd100;
   localparam logic [7:0]  REPLIES_NEEDED_RESET = 8'd1;

   localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
   localparam logic [7:0]  REPLY_MAX   = 8'hFF;

   typedef enum logic [1:0] {
      OP_POLL  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2,
      OP_REPLY = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_START      = 3'd1,
      PH_SEND       = 3'd2,
      PH_WAIT_REPLY = 3'd3,
      PH_WAIT_NEXT  = 3'd4,
      PH_END        = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_SUCCESS = 2'd1,
      ST_FAILURE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  attempt_count;
      logic [31:0] target_address;
      logic        load_address;
   } req_type;

   typedef struct packed {
      logic        send_request;
      logic [31:0] send_address;
      logic [1:0]  status;
      logic [2:0]  phase;
      logic [7:0]  attempts_remaining;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/ping_retry_timeout_sequencer_top.sv]
// Echo-request retry sequencer: state update and registered result.
`default_nettype none

// One result per request transfer. Each transfer updates the sequencer state in
// the cycle it is taken and loads the result register, so a new request is
// taken every cycle while the result register is empty or being drained; the
// result is valid in the next cycle. The user must write the registers through
// the csr port only while the block is idle; the block does not enforce this.
module ping_retry_timeout_sequencer_top
   import prts_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire req_type                    req_payload,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      rsp_type                    rsp_payload,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [15:0] reply_timeout_ff;
   logic [15:0] next_delay_ff;
   logic [7:0]  replies_needed_ff;

   phase_type   phase_ff, phase_in;
   logic        start_pending_ff, start_pending_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic [7:0]  reply_total_ff, reply_total_in;
   logic        reply_flag_ff, reply_flag_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [15:0] wait_limit_ff, wait_limit_in;
   status_type  status_ff, status_in;
   logic [31:0] dest_ff, dest_in;
   logic        send_in;
   logic        timed_out;

   logic        rsp_valid_ff;
   rsp_type     rsp_payload_ff;
   logic        req_xfer;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_xfer    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_timeout_ff  <= REPLY_TIMEOUT_RESET;
         next_delay_ff     <= NEXT_DELAY_RESET;
         replies_needed_ff <= REPLIES_NEEDED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REPLY_TIMEOUT:  reply_timeout_ff  <= csr_write_data;
            CSR_NEXT_DELAY:     next_delay_ff     <= csr_write_data;
            CSR_REPLIES_NEEDED: replies_needed_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      start_pending_in = start_pending_ff;
      attempts_in      = attempts_ff;
      reply_total_in   = reply_total_ff;
      reply_flag_in    = reply_flag_ff;
      elapsed_in       = elapsed_ff;
      wait_limit_in    = wait_limit_ff;
      status_in        = status_ff;
      dest_in          = dest_ff;
      send_in          = 1'b0;
      timed_out        = 1'b0;

      case (opcode_type'(req_payload.opcode))
         OP_START: begin
            start_pending_in = 1'b1;
            attempts_in      = req_payload.attempt_count;
            if (req_payload.load_address) begin
               dest_in   = req_payload.target_address;
               status_in = ST_NONE;
            end
         end
         OP_REPLY: begin
            reply_flag_in = 1'b1;
         end
         default: begin
            if (opcode_type'(req_payload.opcode) == OP_TICK && elapsed_ff != ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 17'd1;
            end
            timed_out = elapsed_in > {1'b0, wait_limit_ff};
            case (phase_ff)
               PH_IDLE: begin
                  if (start_pending_ff) phase_in = PH_START;
               end
               PH_START: begin
                  reply_total_in = '0;
                  if (start_pending_ff && attempts_ff != 8'd0) begin
                     phase_in      = PH_SEND;
                     status_in     = ST_NONE;
                     reply_flag_in = 1'b0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_SEND: begin
                  send_in       = 1'b1;
                  phase_in      = PH_WAIT_REPLY;
                  elapsed_in    = '0;
                  wait_limit_in = reply_timeout_ff;
                  if (attempts_ff != 8'd0) attempts_in = attempts_ff - 8'd1;
               end
               PH_WAIT_REPLY: begin
                  if (reply_flag_ff) begin
                     reply_flag_in = 1'b0;
                     if (reply_total_ff != REPLY_MAX) reply_total_in = reply_total_ff + 8'd1;
                     if (reply_total_in >= replies_needed_ff) begin
                        status_in = ST_SUCCESS;
                        phase_in  = PH_END;
                     end else begin
                        elapsed_in    = '0;
                        wait_limit_in = next_delay_ff;
                        phase_in      = PH_WAIT_NEXT;
                     end
                  end else if (timed_out) begin
                     if (attempts_ff == 8'd0) begin
                        phase_in  = PH_END;
                        status_in = ST_FAILURE;
                     end else begin
                        phase_in = PH_SEND;
                     end
                  end
               end
               PH_WAIT_NEXT: begin
                  if (attempts_ff == 8'd0) begin
                     phase_in  = PH_END;
                     status_in = ST_FAILURE;
                  end else if (timed_out) begin
                     phase_in = PH_SEND;
                  end
               end
               PH_END: begin
                  start_pending_in = 1'b0;
                  attempts_in      = '0;
                  phase_in         = PH_IDLE;
               end
               default: ;
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         start_pending_ff <= 1'b0;
         attempts_ff      <= '0;
         reply_total_ff   <= '0;
         reply_flag_ff    <= 1'b0;
         elapsed_ff       <= '0;
         wait_limit_ff    <= '0;
         status_ff        <= ST_NONE;
         dest_ff          <= '0;
      end else if (req_xfer) begin
         phase_ff         <= phase_in;
         start_pending_ff <= start_pending_in;
         attempts_ff      <= attempts_in;
         reply_total_ff   <= reply_total_in;
         reply_flag_ff    <= reply_flag_in;
         elapsed_ff       <= elapsed_in;
         wait_limit_ff    <= wait_limit_in;
         status_ff        <= status_in;
         dest_ff          <= dest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_payload_ff.send_request       <= send_in;
         rsp_payload_ff.send_address       <= dest_in;
         rsp_payload_ff.status             <= status_in;
         rsp_payload_ff.phase              <= phase_in;
         rsp_payload_ff.attempts_remaining <= attempts_in;
      end
   end

   // a transfer in always produces a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("result missing after request transfer");

   // a send request only leaves while waiting for the reply
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.send_request |-> rsp_payload.phase == PH_WAIT_REPLY)
      else $error("send request outside wait reply");

   // steps never add attempts
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_payload.opcode != OP_START |=>
         attempts_ff == $past(attempts_ff) || attempts_ff == $past(attempts_ff) - 8'd1 ||
         attempts_ff == 8'd0)
      else $error("attempt count grew without a start");

   // success is only declared on entry to the end phase
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && status_ff != ST_SUCCESS && status_in == ST_SUCCESS |-> phase_in == PH_END)
      else $error("success outside end phase");

endmodule

`default_nettype wire

[tb/tb_ping_retry_timeout_sequencer_top.sv]
// Testbench for the echo-request retry sequencer: directed and random transfers against a local model.
`default_nettype none

module tb_ping_retry_timeout_sequencer_top;
   import prts_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 480;
   localparam int DRAIN_CYCLES = 4;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   ping_retry_timeout_sequencer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // sequencer model state and configuration
   logic [15:0] cfg_reply_timeout  = REPLY_TIMEOUT_RESET;
   logic [15:0] cfg_next_delay     = NEXT_DELAY_RESET;
   logic [7:0]  cfg_replies_needed = REPLIES_NEEDED_RESET;
   phase_type   seq_phase          = PH_IDLE;
   logic        seq_start_pending  = 1'b0;
   logic [7:0]  seq_attempts       = '0;
   logic [7:0]  seq_reply_total    = '0;
   logic        seq_reply_flag     = 1'b0;
   logic [16:0] seq_elapsed        = '0;
   logic [15:0] seq_wait_limit     = '0;
   status_type  seq_status         = ST_NONE;
   logic [31:0] seq_dest           = '0;

   rsp_type pending_results[$];
   int      fail_count   = 0;
   int      stall_cycles = 0;
   bit      idle_on      = 1'b1;

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin : rsp_ready_gen
      if (stall_cycles != 0) begin
         stall_cycles--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_cycles = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic rsp_type predict_sequencer(input req_type item);
      rsp_type result;
      logic    sent;
      sent = 1'b0;
      case (item.opcode)
         OP_POLL, OP_TICK: begin
            if (item.opcode == OP_TICK && seq_elapsed != ELAPSED_MAX) seq_elapsed++;
            case (seq_phase)
               PH_IDLE: begin
                  if (seq_start_pending) seq_phase = PH_START;
               end
               PH_START: begin
                  seq_reply_total = '0;
                  if (seq_start_pending && seq_attempts != 0) begin
                     seq_phase      = PH_SEND;
                     seq_status     = ST_NONE;
                     seq_reply_flag = 1'b0;
                  end else begin
                     seq_phase = PH_IDLE;
                  end
               end
               PH_SEND: begin
                  sent           = 1'b1;
                  seq_phase      = PH_WAIT_REPLY;
                  seq_elapsed    = '0;
                  seq_wait_limit = cfg_reply_timeout;
                  if (seq_attempts != 0) seq_attempts--;
               end
               PH_WAIT_REPLY: begin
                  if (seq_reply_flag) begin
                     seq_reply_flag = 1'b0;
                     if (seq_reply_total != REPLY_MAX) seq_reply_total++;
                     if (seq_reply_total >= cfg_replies_needed) begin
                        seq_status = ST_SUCCESS;
                        seq_phase  = PH_END;
                     end else begin
                        seq_elapsed    = '0;
                        seq_wait_limit = cfg_next_delay;
                        seq_phase      = PH_WAIT_NEXT;
                     end
                  end else if (seq_elapsed > seq_wait_limit) begin
                     if (seq_attempts == 0) begin
                        seq_phase  = PH_END;
                        seq_status = ST_FAILURE;
                     end else begin
                        seq_phase = PH_SEND;
                     end
                  end
               end
               PH_WAIT_NEXT: begin
                  if (seq_attempts == 0) begin
                     seq_phase  = PH_END;
                     seq_status = ST_FAILURE;
                  end else if (seq_elapsed > seq_wait_limit) begin
                     seq_phase = PH_SEND;
                  end
               end
               PH_END: begin
                  seq_start_pending = 1'b0;
                  seq_attempts      = '0;
                  seq_phase         = PH_IDLE;
               end
               default: ;
            endcase
         end
         OP_START: begin
            seq_start_pending = 1'b1;
            seq_attempts      = item.attempt_count;
            if (item.load_address) begin
               seq_dest   = item.target_address;
               seq_status = ST_NONE;
            end
         end
         default: seq_reply_flag = 1'b1;
      endcase
      result.send_request       = sent;
      result.send_address       = seq_dest;
      result.status             = seq_status;
      result.phase              = seq_phase;
      result.attempts_remaining = seq_attempts;
      return result;
   endfunction

   task automatic check_field(input string name, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
      if (actual_value !== expected_value) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected_value, actual_value);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("rsp transfer with no result pending: %p", rsp_payload);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("send_request", 32'(want.send_request),
                        32'(rsp_payload.send_request));
            check_field("send_address", want.send_address, rsp_payload.send_address);
            check_field("status", 32'(want.status), 32'(rsp_payload.status));
            check_field("phase", 32'(want.phase), 32'(rsp_payload.phase));
            check_field("attempts_remaining", 32'(want.attempts_remaining),
                        32'(rsp_payload.attempts_remaining));
         end
      end
   end

   function automatic req_type random_item(input opcode_type op);
      req_type item;
      item.opcode         = op;
      item.attempt_count  = 8'($urandom_range(0, 255));
      item.target_address = $urandom;
      item.load_address   = 1'($urandom_range(0, 1));
      return item;
   endfunction

   task automatic send_item(input req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_sequencer(item));
   endtask

   task automatic send_op(input opcode_type op);
      send_item(random_item(op));
   endtask

   task automatic send_start(input logic [7:0] count, input logic [31:0] address,
                             input logic load);
      req_type item;
      item                = random_item(OP_START);
      item.attempt_count  = count;
      item.target_address = address;
      item.load_address   = load;
      send_item(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_REPLY_TIMEOUT:  cfg_reply_timeout  = value;
         CSR_NEXT_DELAY:     cfg_next_delay     = value;
         CSR_REPLIES_NEEDED: cfg_replies_needed = value[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [15:0] reply_timeout, input logic [15:0] next_delay,
                               input logic [7:0] replies_needed);
      drain_results();
      write_csr(CSR_REPLY_TIMEOUT, reply_timeout);
      write_csr(CSR_NEXT_DELAY, next_delay);
      write_csr(CSR_REPLIES_NEEDED, {8'd0, replies_needed});
   endtask

   function automatic logic [15:0] random_timer();
      if ($urandom_range(0, 7) == 0) return 16'($urandom_range(1, 65535));
      return 16'($urandom_range(1, 6));
   endfunction

   // reset configuration, one reply, success and return to idle
   task automatic test_default_success();
      send_start(8'd3, 32'hFFFF_FFFF, 1'b1);
      repeat (3) send_op(OP_POLL);
      send_op(OP_REPLY);
      repeat (2) send_op(OP_POLL);
   endtask

   // start with no attempts toggles between start and idle
   task automatic test_zero_attempts();
      send_start(8'd0, 32'h0000_0000, 1'b1);
      repeat (3) send_op(OP_POLL);
   endtask

   // send after attempts were cleared, then a start lost at end
   task automatic test_send_without_attempts();
      send_start(8'd1, 32'h5A5A_A5A5, 1'b0);
      repeat (2) send_op(OP_POLL);
      send_start(8'd0, 32'h1234_5678, 1'b0);
      send_op(OP_POLL);
      send_op(OP_REPLY);
      send_op(OP_POLL);
      send_start(8'd5, 32'hA5A5_5A5A, 1'b1);
      repeat (2) send_op(OP_POLL);
   endtask

   // shortest timeouts: fail on last attempt, then a retry path
   task automatic test_timeout_paths();
      apply_config(16'd1, 16'd1, 8'd1);
      send_start(8'd1, 32'hC0A8_0001, 1'b1);
      repeat (3) send_op(OP_POLL);
      repeat (2) send_op(OP_TICK);
      send_op(OP_POLL);
      send_start(8'd2, 32'h0A00_0001, 1'b0);
      repeat (3) send_op(OP_POLL);
      repeat (2) send_op(OP_TICK);
      send_op(OP_POLL);
   endtask

   // wait next and wait reply timers checked at their exact boundary
   task automatic test_long_timers();
      idle_on = 1'b0;
      apply_config(16'd40, 16'd40, 8'd2);
      send_start(8'd2, $urandom, 1'b1);
      repeat (3) send_op(OP_POLL);
      send_op(OP_REPLY);
      send_op(OP_POLL);
      repeat (41) send_op(OP_TICK);
      send_op(OP_POLL);
      repeat (42) send_op(OP_TICK);
      drain_results();
      idle_on = 1'b1;
   endtask

   // multi-reply goal with every attempt used
   task automatic test_reply_goal_max();
      apply_config(16'd3, 16'd1, 8'd8);
      send_start(8'd8, $urandom, 1'b1);
      repeat (2) send_op(OP_POLL);
      repeat (8) begin
         send_op(OP_POLL);
         send_op(OP_REPLY);
         send_op(OP_POLL);
         repeat (2) send_op(OP_TICK);
      end
   endtask

   task automatic test_random_sequences();
      int count;
      int len;
      int pick;
      count = 0;
      while (count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0)
            apply_config(random_timer(), random_timer(), 8'($urandom_range(1, 3)));
         idle_on = (count < RANDOM_ITEMS - 120);
         if ($urandom_range(0, 7) == 0)
            send_start(8'($urandom_range(0, 255)), $urandom, 1'($urandom));
         else send_start(8'($urandom_range(0, 4)), $urandom, 1'($urandom));
         len = $urandom_range(4, 40);
         repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) send_op(OP_TICK);
            else if (pick < 65) send_op(OP_POLL);
            else if (pick < 88) send_op(OP_REPLY);
            else send_op(OP_START);
         end
         count += len + 1;
      end
   endtask

   initial begin : test_sequence
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_success();
      test_zero_attempts();
      test_send_without_attempts();
      test_timeout_paths();
      test_long_timers();
      test_reply_goal_max();
      test_random_sequences();
      drain_results();
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
